>>> rtl/core/ges_pkg.sv
// Package with the sizes, codes and address helpers of the graph edge store.
package ges_pkg;

	// Graph size.
	localparam int NODE_COUNT = 32;
	localparam int MAX_DEGREE = 8;

	// Field and storage widths.
	localparam int NODE_FW    = 5;
	localparam int NODE_W     = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int DEG_W      = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
	localparam int CNT_W      = $clog2(MAX_DEGREE + 1);
	localparam int MEM_DEPTH  = NODE_COUNT * MAX_DEGREE;
	localparam int ADDR_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	typedef logic [NODE_FW-1:0] node_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [DEG_W-1:0]   slot_t;
	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [1:0]         action_t;
	typedef logic [1:0]         status_t;

	// Request codes.
	localparam action_t ACT_ADD     = 2'd0;
	localparam action_t ACT_ONE_HOP = 2'd1;
	localparam action_t ACT_TWO_HOP = 2'd2;

	// Result codes.
	localparam status_t ST_EXISTS  = 2'd0;
	localparam status_t ST_ADDED   = 2'd1;
	localparam status_t ST_FULL    = 2'd3;
	localparam status_t ST_ABSENT  = 2'd0;
	localparam status_t ST_PRESENT = 2'd1;
	localparam status_t ST_NONE    = 2'd0;
	localparam status_t ST_VIA_ONE = 2'd1;
	localparam status_t ST_DIRECT  = 2'd2;

	// Edge memory access.
	typedef struct packed {
		logic  re;
		logic  we;
		addr_t addr;
		node_t wdata;
	} mem_req_t;

	// List count update.
	typedef struct packed {
		logic  en;
		node_t node;
		cnt_t  value;
	} cnt_wr_t;

	// True for a node index that lies inside the graph.
	function automatic logic node_ok(node_t n);
		return 32'(n) < NODE_COUNT;
	endfunction

	// Memory address of entry k in the list of node n.
	function automatic addr_t slot_addr(node_t n, cnt_t k);
		return ADDR_W'(32'(n) * MAX_DEGREE + 32'(k));
	endfunction

	// Count limited to the list capacity.
	function automatic cnt_t clip_cnt(cnt_t c);
		return (32'(c) > MAX_DEGREE) ? CNT_W'(MAX_DEGREE) : c;
	endfunction

endpackage

>>> rtl/core/ges_ram.sv
// Generic single-port synchronous RAM with a registered read.
module ges_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     re,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One access per cycle; read data is registered and appears in the next cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

>>> rtl/core/ges_cnt.sv
// Per-node list counts, cleared at reset, one read and one write port.
module ges_cnt
	import ges_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  node_t   rd_node,
	input  cnt_wr_t wr,
	output cnt_t    rd_count
);

	cnt_t count_q [NODE_COUNT];

	// Counts start empty and grow by one on every added edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NODE_COUNT; i++) begin
				count_q[i] <= '0;
			end
		end else if (wr.en && node_ok(wr.node)) begin
			count_q[wr.node[NODE_W-1:0]] <= wr.value;
		end
	end

	// A node outside the graph reads as an empty list.
	assign rd_count = node_ok(rd_node) ? count_q[rd_node[NODE_W-1:0]] : '0;

endmodule

>>> rtl/core/ges_ctrl.sv
// Sequencer that scans adjacency lists in the edge memory and forms the status.
module ges_ctrl
	import ges_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  action_t  action,
	input  node_t    src_node,
	input  node_t    dst_node,
	output logic     busy,
	output logic     done,
	output status_t  status,
	output mem_req_t mem_req,
	input  node_t    mem_rdata,
	output node_t    cnt_rd_node,
	input  cnt_t     cnt_rd_count,
	output cnt_wr_t  cnt_wr
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CNT,
		S_DIR,
		S_OUT,
		S_IN
	} state_t;

	state_t  state_q;
	action_t act_q;
	node_t   src_q;
	node_t   dst_q;
	node_t   mid_q;
	cnt_t    c_q;
	cnt_t    cm_q;
	cnt_t    k_q;
	cnt_t    j_q;
	logic    done_q;
	status_t status_q;

	logic  hit;
	cnt_t  c_now;
	cnt_t  mid_cnt;
	logic  k_more;
	logic  j_more;
	logic  bad_req;
	logic  dir_miss;

	assign hit     = (mem_rdata == dst_q);
	assign c_now   = (state_q == S_CNT) ? clip_cnt(cnt_rd_count) : c_q;
	assign mid_cnt = node_ok(mem_rdata) ? clip_cnt(cnt_rd_count) : '0;
	assign k_more  = (CNT_W'(k_q + 1'b1) < ((state_q == S_IN) ? cm_q : c_q));
	assign j_more  = (CNT_W'(j_q + 1'b1) < c_q);

	// Requests that finish without touching the memory.
	always_comb begin
		case (act_q)
			ACT_ADD:     bad_req = !node_ok(src_q) || !node_ok(dst_q);
			ACT_ONE_HOP: bad_req = !node_ok(src_q);
			ACT_TWO_HOP: bad_req = !node_ok(src_q);
			default:     bad_req = 1'b1;
		endcase
	end

	// The direct scan of the source list has ended without a match.
	assign dir_miss = ((state_q == S_CNT) && !bad_req && (c_now == '0)) ||
	                  ((state_q == S_DIR) && !hit && !k_more);

	// Memory and count port requests.
	always_comb begin
		mem_req     = '0;
		cnt_wr      = '0;
		cnt_rd_node = (state_q == S_OUT) ? mem_rdata : src_q;
		case (state_q)
			S_CNT: begin
				if (!bad_req && c_now != '0) begin
					mem_req.re   = 1'b1;
					mem_req.addr = slot_addr(src_q, '0);
				end
			end
			S_DIR: begin
				if (!hit && k_more) begin
					mem_req.re   = 1'b1;
					mem_req.addr = slot_addr(src_q, CNT_W'(k_q + 1'b1));
				end
			end
			S_OUT: begin
				if (mid_cnt != '0) begin
					mem_req.re   = 1'b1;
					mem_req.addr = slot_addr(mem_rdata, '0);
				end else if (j_more) begin
					mem_req.re   = 1'b1;
					mem_req.addr = slot_addr(src_q, CNT_W'(j_q + 1'b1));
				end
			end
			S_IN: begin
				if (!hit) begin
					if (k_more) begin
						mem_req.re   = 1'b1;
						mem_req.addr = slot_addr(mid_q, CNT_W'(k_q + 1'b1));
					end else if (j_more) begin
						mem_req.re   = 1'b1;
						mem_req.addr = slot_addr(src_q, CNT_W'(j_q + 1'b1));
					end
				end
			end
			default: begin
			end
		endcase
		// End of a missed direct scan: append for an add with room, start the outer scan for a two-hop query.
		if (dir_miss) begin
			if (act_q == ACT_ADD && 32'(c_now) < MAX_DEGREE) begin
				mem_req.we    = 1'b1;
				mem_req.addr  = slot_addr(src_q, c_now);
				mem_req.wdata = dst_q;
				cnt_wr.en     = 1'b1;
				cnt_wr.node   = src_q;
				cnt_wr.value  = CNT_W'(c_now + 1'b1);
			end else if (act_q == ACT_TWO_HOP && c_now != '0) begin
				mem_req.re   = 1'b1;
				mem_req.addr = slot_addr(src_q, '0);
			end
		end
	end

	// State, counters and the registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			status_q <= ST_NONE;
			act_q    <= ACT_ADD;
			src_q    <= '0;
			dst_q    <= '0;
			mid_q    <= '0;
			c_q      <= '0;
			cm_q     <= '0;
			k_q      <= '0;
			j_q      <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						act_q   <= action;
						src_q   <= src_node;
						dst_q   <= dst_node;
						state_q <= S_CNT;
					end
				end
				S_CNT: begin
					c_q <= c_now;
					k_q <= '0;
					j_q <= '0;
					if (bad_req) begin
						done_q   <= 1'b1;
						status_q <= (act_q == ACT_ADD) ? ST_FULL : ST_NONE;
						state_q  <= S_IDLE;
					end else if (c_now != '0) begin
						state_q <= S_DIR;
					end
				end
				S_DIR: begin
					if (hit) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
						case (act_q)
							ACT_ADD:     status_q <= ST_EXISTS;
							ACT_ONE_HOP: status_q <= ST_PRESENT;
							default:     status_q <= ST_DIRECT;
						endcase
					end else if (k_more) begin
						k_q <= CNT_W'(k_q + 1'b1);
					end
				end
				S_OUT: begin
					mid_q <= mem_rdata;
					cm_q  <= mid_cnt;
					if (mid_cnt != '0) begin
						k_q     <= '0;
						state_q <= S_IN;
					end else if (j_more) begin
						j_q <= CNT_W'(j_q + 1'b1);
					end else begin
						done_q   <= 1'b1;
						status_q <= ST_NONE;
						state_q  <= S_IDLE;
					end
				end
				S_IN: begin
					if (hit) begin
						done_q   <= 1'b1;
						status_q <= ST_VIA_ONE;
						state_q  <= S_IDLE;
					end else if (k_more) begin
						k_q <= CNT_W'(k_q + 1'b1);
					end else if (j_more) begin
						j_q     <= CNT_W'(j_q + 1'b1);
						state_q <= S_OUT;
					end else begin
						done_q   <= 1'b1;
						status_q <= ST_NONE;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// A missed direct scan at once decides adds, one-hop queries and two-hop queries from an empty list.
			if (dir_miss) begin
				case (act_q)
					ACT_ADD: begin
						done_q   <= 1'b1;
						status_q <= (32'(c_now) < MAX_DEGREE) ? ST_ADDED : ST_FULL;
						state_q  <= S_IDLE;
					end
					ACT_TWO_HOP: begin
						if (c_now != '0) begin
							state_q <= S_OUT;
						end else begin
							done_q   <= 1'b1;
							status_q <= ST_NONE;
							state_q  <= S_IDLE;
						end
					end
					default: begin
						done_q   <= 1'b1;
						status_q <= ST_ABSENT;
						state_q  <= S_IDLE;
					end
				endcase
			end
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign status = status_q;

endmodule

>>> rtl/core/graph_edge_store_two_hop_query.sv
// Directed graph edge store with add, one-hop and two-hop reachability requests.
// A transaction is taken when start is high and busy is low; the status comes back
// on a one-cycle done strobe that cannot be held off, and busy is already low in
// that cycle so the next transaction may start at once. All adjacency lists share
// one edge memory port that reads one list entry per cycle. An add or a one-hop
// query scans the source list; a two-hop query scans it for a direct edge and then
// scans the list of each intermediate node in turn. There is no clearing pass after
// reset: the per-node counts reset to zero and only entries below a count are ever
// read.
module graph_edge_store_two_hop_query
	import ges_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  action_t action,
	input  node_t   src_node,
	input  node_t   dst_node,
	output logic    done,
	output status_t status
);

	mem_req_t mem_req;
	node_t    mem_rdata;
	node_t    cnt_rd_node;
	cnt_t     cnt_rd_count;
	cnt_wr_t  cnt_wr;

	// Request sequencer.
	ges_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.action       (action),
		.src_node     (src_node),
		.dst_node     (dst_node),
		.busy         (busy),
		.done         (done),
		.status       (status),
		.mem_req      (mem_req),
		.mem_rdata    (mem_rdata),
		.cnt_rd_node  (cnt_rd_node),
		.cnt_rd_count (cnt_rd_count),
		.cnt_wr       (cnt_wr)
	);

	// Adjacency list entries, one slot block per node.
	ges_ram #(
		.WIDTH (NODE_FW),
		.DEPTH (MEM_DEPTH)
	) u_edge_ram (
		.clk   (clk),
		.re    (mem_req.re),
		.we    (mem_req.we),
		.addr  (mem_req.addr),
		.wdata (mem_req.wdata),
		.rdata (mem_rdata)
	);

	// Per-node list lengths.
	ges_cnt u_cnt (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_node  (cnt_rd_node),
		.wr       (cnt_wr),
		.rd_count (cnt_rd_count)
	);

endmodule

>>> tb/graph_edge_store_two_hop_query_test.sv
// Self-checking testbench for the graph edge store with one-hop and two-hop queries.
`timescale 1ns / 1ps

module graph_edge_store_two_hop_query_test;
	import ges_pkg::*;

	// Unused action code, which the block answers with ST_NONE without touching the memory.
	localparam action_t ACT_SPARE = 2'd3;

	localparam int RANDOM_ITEMS = 450;
	// Items from this index onwards are sent without idle cycles.
	localparam int QUIET_FROM   = 420;
	localparam int TAIL_CYCLES  = 100;

	typedef struct {
		action_t     act;
		node_t       src;
		node_t       dst;
		int unsigned gap;
		bit          drain;
	} request_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	logic    busy;
	action_t action = ACT_ADD;
	node_t   src_node = '0;
	node_t   dst_node = '0;
	logic    done;
	status_t status;

	request_t    pending_requests[$];
	status_t     status_due[$];
	request_t    cur;
	request_t    nxt;
	logic        have_next = 1'b0;
	logic        in_flight = 1'b0;
	int unsigned hold_cnt = 0;
	int unsigned fail_cnt = 0;

	// Mirror of the adjacency lists.
	node_t       adj_list[NODE_COUNT][MAX_DEGREE];
	int unsigned adj_len[NODE_COUNT];

	graph_edge_store_two_hop_query uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.action   (action),
		.src_node (src_node),
		.dst_node (dst_node),
		.done     (done),
		.status   (status)
	);

	always #10 clk = ~clk;

	// True when the mirrored list of src holds dst.
	function automatic bit has_arc(node_t src, node_t dst);
		if (32'(src) >= NODE_COUNT)
			return 1'b0;
		for (int k = 0; k < adj_len[src]; k++) begin
			if (adj_list[src][k] == dst)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// Applies one request to the mirror and returns the status the block should report.
	function automatic status_t graph_answer(action_t act, node_t src, node_t dst);
		case (act)
			ACT_ADD: begin
				if (32'(src) >= NODE_COUNT || 32'(dst) >= NODE_COUNT)
					return ST_FULL;
				if (has_arc(src, dst))
					return ST_EXISTS;
				if (adj_len[src] >= MAX_DEGREE)
					return ST_FULL;
				adj_list[src][adj_len[src]] = dst;
				adj_len[src]++;
				return ST_ADDED;
			end
			ACT_ONE_HOP: begin
				return has_arc(src, dst) ? ST_PRESENT : ST_ABSENT;
			end
			ACT_TWO_HOP: begin
				if (has_arc(src, dst))
					return ST_DIRECT;
				if (32'(src) >= NODE_COUNT)
					return ST_NONE;
				for (int k = 0; k < adj_len[src]; k++) begin
					if (has_arc(adj_list[src][k], dst))
						return ST_VIA_ONE;
				end
				return ST_NONE;
			end
			default: begin
				return ST_NONE;
			end
		endcase
	endfunction

	// Queues one request; idle bursts come in alternating stretches and stop near the end.
	task automatic push_req(action_t act, node_t src, node_t dst, bit drain);
		request_t    r;
		int unsigned idx;
		idx = pending_requests.size();
		r.act = act;
		r.src = src;
		r.dst = dst;
		r.drain = drain;
		r.gap = 0;
		if (idx < QUIET_FROM && (idx / 40) % 2 == 0 && $urandom_range(0, 2) == 0)
			r.gap = $urandom_range(1, 4);
		pending_requests.push_back(r);
	endtask

	// Mostly a small group of nodes so that lists fill up and paths form.
	function automatic node_t pick_node();
		if ($urandom_range(0, 9) < 7)
			return node_t'($urandom_range(0, 7));
		return node_t'($urandom_range(0, 31));
	endfunction

	// Driver: presents queued requests and predicts each accepted transaction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			action <= ACT_ADD;
			src_node <= '0;
			dst_node <= '0;
			in_flight = 1'b0;
			have_next = 1'b0;
			hold_cnt = 0;
		end else begin
			if (done)
				in_flight = 1'b0;
			if (start && !busy) begin
				status_due.push_back(graph_answer(cur.act, cur.src, cur.dst));
				in_flight = 1'b1;
			end
			if (!start || !busy) begin
				if (!have_next && pending_requests.size() != 0) begin
					nxt = pending_requests.pop_front();
					have_next = 1'b1;
					hold_cnt = nxt.gap;
				end
				if (have_next && hold_cnt == 0 && !(nxt.drain && in_flight)) begin
					cur = nxt;
					have_next = 1'b0;
					start <= 1'b1;
					action <= nxt.act;
					src_node <= nxt.src;
					dst_node <= nxt.dst;
				end else begin
					// Idle cycles count only once the block is free.
					if (have_next && hold_cnt != 0 && !busy)
						hold_cnt--;
					start <= 1'b0;
					action <= action_t'($urandom_range(0, 3));
					src_node <= node_t'($urandom_range(0, 31));
					dst_node <= node_t'($urandom_range(0, 31));
				end
			end
		end
	end

	// Monitor: compares each strobed status with the oldest prediction.
	always @(posedge clk) begin
		status_t want;
		if (arst_n && done) begin
			if (status_due.size() == 0) begin
				$error("status: expected none, actual %0d", status);
				fail_cnt++;
			end else begin
				want = status_due.pop_front();
				if (status !== want) begin
					$error("status: expected %0d, actual %0d", want, status);
					fail_cnt++;
				end
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		action_t     act;
		int unsigned r;

		// Empty graph, extremes of the node range.
		push_req(ACT_TWO_HOP, 5'd0, 5'd0, 1'b0);
		push_req(ACT_ONE_HOP, 5'd31, 5'd31, 1'b0);
		// Added edge, then the same edge again.
		push_req(ACT_ADD, 5'd0, 5'd1, 1'b0);
		push_req(ACT_ADD, 5'd0, 5'd1, 1'b0);
		// Self loop.
		push_req(ACT_ADD, 5'd31, 5'd31, 1'b0);
		push_req(ACT_ONE_HOP, 5'd31, 5'd31, 1'b0);
		push_req(ACT_TWO_HOP, 5'd31, 5'd31, 1'b0);
		// Path through one intermediate node, and no path at all.
		push_req(ACT_ADD, 5'd1, 5'd2, 1'b0);
		push_req(ACT_TWO_HOP, 5'd0, 5'd2, 1'b0);
		push_req(ACT_TWO_HOP, 5'd0, 5'd3, 1'b0);
		// Fill one list, overflow it, then a duplicate on the full list.
		for (int k = 0; k < MAX_DEGREE; k++)
			push_req(ACT_ADD, 5'd5, node_t'(k), 1'b0);
		push_req(ACT_ADD, 5'd5, 5'd8, 1'b0);
		push_req(ACT_ADD, 5'd5, 5'd3, 1'b0);
		// Unused action code, sent once everything before it has answered.
		push_req(ACT_SPARE, 5'd31, 5'd31, 1'b1);
		push_req(ACT_ADD, 5'd31, 5'd0, 1'b0);
		push_req(ACT_TWO_HOP, 5'd5, 5'd31, 1'b0);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			r = $urandom_range(0, 99);
			if (r < 35)
				act = ACT_ADD;
			else if (r < 60)
				act = ACT_ONE_HOP;
			else if (r < 95)
				act = ACT_TWO_HOP;
			else
				act = ACT_SPARE;
			push_req(act, pick_node(), pick_node(), i == RANDOM_ITEMS / 2);
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_requests.size() != 0 || have_next || start || in_flight)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (status_due.size() != 0) begin
			$error("status: %0d transactions never answered", status_due.size());
			fail_cnt++;
		end
		if (fail_cnt == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#(5_000_000);
		$display("FAIL");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/ges_pkg.sv
rtl/core/ges_ram.sv
rtl/core/ges_cnt.sv
rtl/core/ges_ctrl.sv
rtl/core/graph_edge_store_two_hop_query.sv
tb/graph_edge_store_two_hop_query_test.sv
